/* hdl/wab_pkg.sv */
// ----------------------------------------------------------------------------
// wab_pkg: shared types, constants and functions for the weighted blend
// Widths, fixed-point scale factors and the pipeline control structure
// used by every module of the blender.
// ----------------------------------------------------------------------------
package wab_pkg;

	// Field widths.
	localparam int CHAN_W           = 8;
	localparam int WEIGHT_W         = 16;
	localparam int WEIGHT_FRAC_BITS = 12;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1 << WEIGHT_FRAC_BITS);

	// Pipeline depth in register stages.
	localparam int NUM_STAGES = 4;

	// Product src_alpha * weight, the signed color product and the sum.
	localparam int SAW_W  = CHAN_W + WEIGHT_W;
	localparam int DIFF_W = CHAN_W + 1;
	localparam int PROD_W = DIFF_W + SAW_W + 1;
	localparam int V_W    = PROD_W + 1;

	// Destination term d * 255 * 2^F and the scaled clamp limits.
	localparam int DK_W = 2 * CHAN_W + WEIGHT_FRAC_BITS;
	localparam longint CLAMP_TOP = longint'(255 * 255) <<< WEIGHT_FRAC_BITS;
	localparam int X_W = 2 * CHAN_W;
	localparam logic [X_W-1:0] X_MAX = X_W'(255 * 255);

	// Weighted source alpha for the alpha channel: src_alpha * w / 2^(F+1).
	localparam int SAH_W = SAW_W - WEIGHT_FRAC_BITS - 1;
	localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

	// Per-stage advance enables and valid bits, index 0 is stage 1.
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} pipe_ctl_t;

	// Exact floor(x / 255) for x up to 255 * 255.
	function automatic logic [CHAN_W-1:0] div255(input logic [X_W-1:0] x);
		logic [X_W:0] t;
		t = {1'b0, x} + {{(CHAN_W + 1){1'b0}}, x[X_W-1:CHAN_W]} + (X_W + 1)'(1);
		return t[X_W-1:CHAN_W];
	endfunction

endpackage

/* hdl/wab_ctrl.sv */
// ----------------------------------------------------------------------------
// wab_ctrl: valid and stall control for the blend pipeline
// Tracks a valid bit per stage and lets each stage advance when the stage
// after it is empty or advancing, so bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module wab_ctrl
	import wab_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output pipe_ctl_t ctl
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [NUM_STAGES-1:0] en;

	// A stage may load when it is empty or its content moves on.
	always_comb begin
		en[3] = !vld_s4 || !out_stall;
		en[2] = !vld_s3 || en[3];
		en[1] = !vld_s2 || en[2];
		en[0] = !vld_s1 || en[1];
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en[0]) vld_s1 <= in_valid;
			if (en[1]) vld_s2 <= vld_s1;
			if (en[2]) vld_s3 <= vld_s2;
			if (en[3]) vld_s4 <= vld_s3;
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = vld_s4;
	assign ctl.en    = en;
	assign ctl.vld   = {vld_s4, vld_s3, vld_s2, vld_s1};

endmodule

/* hdl/wab_chan.sv */
// ----------------------------------------------------------------------------
// wab_chan: four-stage datapath for one color channel
// Computes d*255*2^F + (s-d)*sa*w, clamps it and divides by 255*2^F.
// ----------------------------------------------------------------------------
module wab_chan
	import wab_pkg::*;
(
	input  logic              clk,
	input  pipe_ctl_t         ctl,
	input  logic [CHAN_W-1:0] dst,
	input  logic [CHAN_W-1:0] src,
	input  logic [SAW_W-1:0]  saw_s1,
	output logic [CHAN_W-1:0] result
);

	logic        [CHAN_W-1:0] d_s1, d_s2;
	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic        [X_W-1:0]    x_s3;
	logic        [CHAN_W-1:0] out_s4;

	logic [X_W-1:0]       d255;
	logic [DK_W-1:0]      dk;
	logic signed [V_W-1:0] v;
	logic [X_W-1:0]       x_next;

	// Stage 1: register the destination and the signed difference.
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			d_s1    <= dst;
			diff_s1 <= $signed({1'b0, src}) - $signed({1'b0, dst});
		end
	end

	// Stage 2: signed difference times the weighted source alpha.
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			d_s2    <= d_s1;
			prod_s2 <= PROD_W'(diff_s1) * $signed({1'b0, saw_s1});
		end
	end

	// Stage 3: add the destination term and clamp, keeping v / 2^F.
	always_comb begin
		d255 = {d_s2, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, d_s2};
		dk   = DK_W'(d255) << WEIGHT_FRAC_BITS;
		v    = $signed(V_W'(dk)) + V_W'(prod_s2);
		if (v[V_W-1]) begin
			x_next = '0;
		end else if (v > $signed(V_W'(CLAMP_TOP))) begin
			x_next = X_MAX;
		end else begin
			x_next = v[WEIGHT_FRAC_BITS +: X_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			x_s3 <= x_next;
		end
	end

	// Stage 4: exact division by 255.
	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			out_s4 <= div255(x_s3);
		end
	end

	assign result = out_s4;

endmodule

/* hdl/weighted_alpha_blend_rgba8.sv */
// ----------------------------------------------------------------------------
// weighted_alpha_blend_rgba8: weighted blend of an RGBA8 pixel pair
// Top level with the weight register, the alpha path and three color lanes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one destination and one source pixel per
// transaction (in_valid / in_stall); the output channel returns one blended
// pixel per transaction (out_valid / out_stall). A transaction completes at
// a clock edge where valid is high and stall is low.
// The block is a four-stage pipeline, and one pixel pair is taken every
// cycle while in_stall is low. The stages are: weighted-alpha product,
// color product, sum and clamp, division by 255.
// While the receiver stalls, empty stages still fill, so input is taken
// until all four stages hold data; only then is in_stall raised.
// The blend weight is written through wr_en / blend_weight (Q4.12) and should
// change only while the pipeline is empty. Reset clears every valid bit and
// sets the weight to 1.0 (4096).
// ----------------------------------------------------------------------------
module weighted_alpha_blend_rgba8
	import wab_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [WEIGHT_W-1:0] blend_weight,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CHAN_W-1:0]   dst_red,
	input  logic [CHAN_W-1:0]   dst_green,
	input  logic [CHAN_W-1:0]   dst_blue,
	input  logic [CHAN_W-1:0]   dst_alpha,
	input  logic [CHAN_W-1:0]   src_red,
	input  logic [CHAN_W-1:0]   src_green,
	input  logic [CHAN_W-1:0]   src_blue,
	input  logic [CHAN_W-1:0]   src_alpha,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CHAN_W-1:0]   out_red,
	output logic [CHAN_W-1:0]   out_green,
	output logic [CHAN_W-1:0]   out_blue,
	output logic [CHAN_W-1:0]   out_alpha
);

	pipe_ctl_t ctl;

	logic [WEIGHT_W-1:0] weight_q;
	logic [SAW_W-1:0]    saw_s1;
	logic [CHAN_W-1:0]   da_s1, da_s2;
	logic [SAH_W-1:0]    sah_s2;
	logic [CHAN_W-1:0]   alpha_s3, alpha_s4;
	logic [SAH_W:0]      alpha_sum;

	// Blend weight register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (wr_en) begin
			weight_q <= blend_weight;
		end
	end

	// Pipeline valid and stall control.
	wab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	// Stage 1: source alpha times weight, shared by all channels.
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			saw_s1 <= SAW_W'(src_alpha) * SAW_W'(weight_q);
			da_s1  <= dst_alpha;
		end
	end

	// Alpha path: halve the weighted source alpha, add and saturate.
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			da_s2  <= da_s1;
			sah_s2 <= saw_s1[SAW_W-1 -: SAH_W];
		end
	end

	assign alpha_sum = (SAH_W + 1)'(da_s2) + (SAH_W + 1)'(sah_s2);

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			alpha_s3 <= (alpha_sum > (SAH_W + 1)'(CHAN_MAX)) ? CHAN_MAX
				: alpha_sum[CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			alpha_s4 <= alpha_s3;
		end
	end

	assign out_alpha = alpha_s4;

	// Color lanes.
	wab_chan u_red (
		.clk    (clk),
		.ctl    (ctl),
		.dst    (dst_red),
		.src    (src_red),
		.saw_s1 (saw_s1),
		.result (out_red)
	);

	wab_chan u_green (
		.clk    (clk),
		.ctl    (ctl),
		.dst    (dst_green),
		.src    (src_green),
		.saw_s1 (saw_s1),
		.result (out_green)
	);

	wab_chan u_blue (
		.clk    (clk),
		.ctl    (ctl),
		.dst    (dst_blue),
		.src    (src_blue),
		.saw_s1 (saw_s1),
		.result (out_blue)
	);

`ifndef SYNTH
	// Input is held off only when every stage is full and the output stalls.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (ctl.vld == '1 && out_stall))
		else $error("input stalled while the pipeline had room");

	// An accepted transaction occupies stage 1 on the next cycle.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> ctl.vld[0])
		else $error("accepted transaction lost at stage 1");

	// A delivered result with nothing behind it leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !ctl.vld[2]) |=> !out_valid)
		else $error("result repeated after delivery");
`endif

endmodule

/* test/weighted_alpha_blend_rgba8_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_alpha_blend_rgba8_tb: self-checking bench for the weighted blend
// Streams destination/source pixel pairs through the blender under several
// blend weights, including zero, the nominal range limits and the full
// 16-bit maximum. A scoreboard computes each blended pixel and compares it
// with the pipeline output in order. Both sides stall at random.
// ----------------------------------------------------------------------------

typedef struct {
	logic [7:0] dst_r, dst_g, dst_b, dst_a;
	logic [7:0] src_r, src_g, src_b, src_a;
} pixel_pair_t;

typedef struct {
	logic [7:0] r, g, b, a;
} rgba_pixel_t;

// Scoreboard: keeps a copy of the weight and the queue of pending pixels.
class blend_scoreboard;
	logic [15:0] weight;
	rgba_pixel_t blended_q[$];
	int errors;

	function new();
		weight = wab_pkg::WEIGHT_RESET;
		errors = 0;
	endfunction

	// One color channel: move from dst toward src by sa/255 * w/2^F.
	function logic [7:0] mix_channel(logic [7:0] d, logic [7:0] s, logic [7:0] sa);
		longint scale;
		longint v;
		scale = longint'(255) << wab_pkg::WEIGHT_FRAC_BITS;
		v = longint'(d) * scale + (longint'(s) - longint'(d)) * longint'(sa) * longint'(weight);
		if (v < 0) v = 0;
		if (v > scale * 255) v = scale * 255;
		return 8'(v / scale);
	endfunction

	// Alpha accumulates half the weighted source alpha, saturating at 255.
	function logic [7:0] accumulate_alpha(logic [7:0] da, logic [7:0] sa);
		longint a;
		a = longint'(da) + ((longint'(sa) * longint'(weight)) >>> (wab_pkg::WEIGHT_FRAC_BITS + 1));
		if (a > 255) a = 255;
		return 8'(a);
	endfunction

	function void note_pair(pixel_pair_t p);
		rgba_pixel_t e;
		e.r = mix_channel(p.dst_r, p.src_r, p.src_a);
		e.g = mix_channel(p.dst_g, p.src_g, p.src_a);
		e.b = mix_channel(p.dst_b, p.src_b, p.src_a);
		e.a = accumulate_alpha(p.dst_a, p.src_a);
		blended_q.push_back(e);
	endfunction

	function void check_pixel(rgba_pixel_t got);
		rgba_pixel_t e;
		if (blended_q.size() == 0) begin
			$error("output transaction with no pending pixel: %0d %0d %0d %0d",
				got.r, got.g, got.b, got.a);
			errors++;
			return;
		end
		e = blended_q.pop_front();
		if (got.r !== e.r) begin
			$error("out_red: expected %0d, got %0d", e.r, got.r);
			errors++;
		end
		if (got.g !== e.g) begin
			$error("out_green: expected %0d, got %0d", e.g, got.g);
			errors++;
		end
		if (got.b !== e.b) begin
			$error("out_blue: expected %0d, got %0d", e.b, got.b);
			errors++;
		end
		if (got.a !== e.a) begin
			$error("out_alpha: expected %0d, got %0d", e.a, got.a);
			errors++;
		end
	endfunction

	function int pending();
		return blended_q.size();
	endfunction
endclass

module weighted_alpha_blend_rgba8_tb;
	import wab_pkg::*;

	localparam int HOLD_CYCLES  = 150;
	localparam int STUCK_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 70;

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	logic [WEIGHT_W-1:0] blend_weight;
	logic                in_valid;
	logic                in_stall;
	logic [CHAN_W-1:0]   dst_red, dst_green, dst_blue, dst_alpha;
	logic [CHAN_W-1:0]   src_red, src_green, src_blue, src_alpha;
	logic                out_valid;
	logic                out_stall;
	logic [CHAN_W-1:0]   out_red, out_green, out_blue, out_alpha;

	blend_scoreboard sb;
	bit  quiet;
	bit  hold_req;
	int  stuck_cycles;

	weighted_alpha_blend_rgba8 u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.blend_weight (blend_weight),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.dst_red      (dst_red),
		.dst_green    (dst_green),
		.dst_blue     (dst_blue),
		.dst_alpha    (dst_alpha),
		.src_red      (src_red),
		.src_green    (src_green),
		.src_blue     (src_blue),
		.src_alpha    (src_alpha),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_alpha    (out_alpha)
	);

	// Clock with an 8 ns period.
	always #4 clk = ~clk;

	// Inputs are driven before time zero advances so nothing floats.
	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		wr_en        = 1'b0;
		blend_weight = '0;
		in_valid     = 1'b0;
		out_stall    = 1'b0;
		{dst_red, dst_green, dst_blue, dst_alpha} = '0;
		{src_red, src_green, src_blue, src_alpha} = '0;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		sb           = new();
	end

	// Transactions are recorded and checked at the rising edge.
	always @(posedge clk) begin
		pixel_pair_t p;
		rgba_pixel_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				p.dst_r = dst_red;   p.dst_g = dst_green;
				p.dst_b = dst_blue;  p.dst_a = dst_alpha;
				p.src_r = src_red;   p.src_g = src_green;
				p.src_b = src_blue;  p.src_a = src_alpha;
				sb.note_pair(p);
			end
			if (out_valid && !out_stall) begin
				got.r = out_red;  got.g = out_green;
				got.b = out_blue; got.a = out_alpha;
				sb.check_pixel(got);
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles + 1 >= STUCK_LIMIT) begin
				$display("weighted_alpha_blend_rgba8_tb: FAIL");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off on request.
	initial begin
		int burst_left;
		burst_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req  = 1'b0;
				out_stall = 1'b0;
			end else if (quiet) begin
				out_stall = 1'b0;
			end else begin
				if (burst_left == 0 && $urandom_range(0, 5) == 0)
					burst_left = $urandom_range(1, 10);
				if (burst_left > 0) begin
					out_stall = 1'b1;
					burst_left--;
				end else begin
					out_stall = 1'b0;
				end
			end
		end
	end

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_pair_t make_pair(logic [7:0] dr, logic [7:0] dg, logic [7:0] db,
			logic [7:0] da, logic [7:0] sr, logic [7:0] sg, logic [7:0] sb_, logic [7:0] sa);
		pixel_pair_t p;
		p.dst_r = dr; p.dst_g = dg; p.dst_b = db; p.dst_a = da;
		p.src_r = sr; p.src_g = sg; p.src_b = sb_; p.src_a = sa;
		return p;
	endfunction

	function automatic pixel_pair_t random_pair();
		return make_pair(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
			rand_chan(), rand_chan(), rand_chan(), rand_chan());
	endfunction

	// Offer one pair, with an optional idle gap first, until it is taken.
	task automatic send_pair(pixel_pair_t p);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		dst_red  = p.dst_r; dst_green = p.dst_g; dst_blue = p.dst_b; dst_alpha = p.dst_a;
		src_red  = p.src_r; src_green = p.src_g; src_blue = p.src_b; src_alpha = p.src_a;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
	endtask

	// Drop valid and wait until every pending pixel has come out.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// The weight changes only with the pipeline empty.
	task automatic write_weight(logic [WEIGHT_W-1:0] w);
		drain();
		@(negedge clk);
		wr_en        = 1'b1;
		blend_weight = w;
		sb.weight    = w;
		@(negedge clk);
		wr_en        = 1'b0;
	endtask

	// Extremes, zero source alpha, equal colors and alpha saturation.
	task automatic send_directed();
		send_pair(make_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0));
		send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
		send_pair(make_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255));
		send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255));
		send_pair(make_pair(8'd10,  8'd20,  8'd30,  8'd40,  8'd200, 8'd100, 8'd50,  8'd0));
		send_pair(make_pair(8'd128, 8'd128, 8'd128, 8'd0,   8'd128, 8'd128, 8'd128, 8'd255));
		send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd200, 8'd255, 8'd255, 8'd255, 8'd128));
		send_pair(make_pair(8'd0,   8'd255, 8'd0,   8'd128, 8'd255, 8'd0,   8'd255, 8'd255));
		send_pair(make_pair(8'd1,   8'd1,   8'd1,   8'd1,   8'd254, 8'd254, 8'd254, 8'd1));
		send_pair(make_pair(8'd254, 8'd1,   8'd128, 8'd254, 8'd0,   8'd255, 8'd127, 8'd254));
		send_pair(make_pair(8'h55,  8'h55,  8'h55,  8'h55,  8'hAA,  8'hAA,  8'hAA,  8'hAA));
		send_pair(make_pair(8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'h55,  8'h55,  8'h55,  8'h55));
	endtask

	task automatic send_random(int n);
		repeat (n) send_pair(random_pair());
	endtask

	// Main sequence: reset, then one phase per weight setting.
	initial begin
		logic [WEIGHT_W-1:0] weights [9];
		weights = '{16'd0, 16'd65535, 16'd40960, 16'd1, 16'd2048, 16'd8192,
			16'd0, 16'd0, 16'd4096};
		weights[6] = WEIGHT_W'($urandom_range(0, 40960));
		weights[7] = WEIGHT_W'($urandom_range(0, 65535));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset weight first, with a long receiver hold-off to fill the pipe.
		send_directed();
		hold_req = 1'b1;
		send_random(60);

		foreach (weights[i]) begin
			write_weight(weights[i]);
			if (i == 1)
				send_directed();
			// The final phase runs without any stalls.
			if (i == 8)
				quiet = 1'b1;
			send_random(PHASE_ITEMS);
		end

		drain();
		repeat (NUM_STAGES + 4) @(posedge clk);
		if (sb.errors == 0)
			$display("weighted_alpha_blend_rgba8_tb: PASS");
		else
			$display("weighted_alpha_blend_rgba8_tb: FAIL");
		$finish;
	end

endmodule
